FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i, ignored while rst_ni is low.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a condition on the next rising edge.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tcbsq_pkg.sv
package tcbsq_pkg;

  localparam int HIGH_DEPTH = 16;
  localparam int BULK_DEPTH = 64;

  localparam int HIGH_AW = $clog2(HIGH_DEPTH);
  localparam int HIGH_CW = $clog2(HIGH_DEPTH + 1);
  localparam int BULK_AW = $clog2(BULK_DEPTH);
  localparam int BULK_CW = $clog2(BULK_DEPTH + 1);

  localparam int FUNC_W = 2;
  localparam int LEN_W = 21;
  localparam int TAG_W = 8;
  localparam int HANDLE_W = 16;
  localparam int GEN_W = 16;
  localparam int STAT_W = 3;
  localparam int BYTES_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ENQ = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK = 3'd0;
  localparam logic [STAT_W-1:0] STAT_TOTAL_REJ = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BULK_REJ = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_LIMIT = 2'd1;

  localparam logic [BYTES_W-1:0] TOTAL_LIMIT_RST = BYTES_W'(6 * 1024 * 1024);
  localparam logic [BYTES_W-1:0] BULK_LIMIT_RST = BYTES_W'(2 * 1024 * 1024);

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
    logic [GEN_W-1:0]    gen;
  } desc_t;

endpackage

FILE: hdl/two_class_byte_bounded_send_queue_unit.sv
// Two-class send queue: descriptors wait in a high-priority store and a bulk store, each a
// synchronous RAM with a registered read port. Enqueue, clear and an unused func code load the
// result register in the cycle after they are accepted; a dequeue that finds a packet goes
// through the read state: the descriptor is registered out of the RAM, then the byte counters are
// updated from it and the result register is loaded. One item is in flight at a time: in_ready_o
// is high in the idle state while the output register is empty or being drained. Limits may be
// written at any idle time; lowering one below the backlog only blocks later enqueues.
`include "assert_macros.svh"

module two_class_byte_bounded_send_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcbsq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcbsq_pkg::BYTES_W-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tcbsq_pkg::FUNC_W-1:0]        func_i,
  input  logic [tcbsq_pkg::LEN_W-1:0]         pkt_len_i,
  input  logic                                low_prio_i,
  input  logic [tcbsq_pkg::TAG_W-1:0]         pkt_tag_i,
  input  logic [tcbsq_pkg::HANDLE_W-1:0]      buf_handle_i,
  input  logic [tcbsq_pkg::GEN_W-1:0]         conn_generation_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tcbsq_pkg::STAT_W-1:0]        status_o,
  output logic [tcbsq_pkg::TAG_W-1:0]         out_tag_o,
  output logic [tcbsq_pkg::LEN_W-1:0]         out_len_o,
  output logic [tcbsq_pkg::HANDLE_W-1:0]      out_handle_o,
  output logic                                out_from_bulk_o,
  output logic                                out_deliver_o,
  output logic [tcbsq_pkg::BYTES_W-1:0]       bulk_backlog_o,
  output logic [tcbsq_pkg::BYTES_W-1:0]       total_backlog_o
);

  localparam int HIGH_SW = tcbsq_pkg::HIGH_CW + 1;
  localparam int BULK_SW = tcbsq_pkg::BULK_CW + 1;
  localparam int BYTES_W = tcbsq_pkg::BYTES_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // descriptor stores
  tcbsq_pkg::desc_t high_mem [tcbsq_pkg::HIGH_DEPTH];
  tcbsq_pkg::desc_t bulk_mem [tcbsq_pkg::BULK_DEPTH];
  tcbsq_pkg::desc_t high_rd_q, bulk_rd_q, rd_desc, new_desc;

  logic                            state_q, state_d;
  logic [tcbsq_pkg::HIGH_AW-1:0]   high_head_q, high_head_d, high_tail;
  logic [tcbsq_pkg::HIGH_CW-1:0]   high_count_q, high_count_d;
  logic [tcbsq_pkg::BULK_AW-1:0]   bulk_head_q, bulk_head_d, bulk_tail;
  logic [tcbsq_pkg::BULK_CW-1:0]   bulk_count_q, bulk_count_d;
  logic [BYTES_W-1:0]              queued_total_q, queued_total_d;
  logic [BYTES_W-1:0]              queued_bulk_q, queued_bulk_d;
  logic [BYTES_W-1:0]              total_limit_q, bulk_limit_q;
  logic                            sel_bulk_q, sel_bulk_d;
  logic [tcbsq_pkg::GEN_W-1:0]     gen_q;

  logic [HIGH_SW-1:0]              high_tail_sum;
  logic [BULK_SW-1:0]              bulk_tail_sum;
  logic [BYTES_W:0]                total_sum, bulk_sum;
  logic                            over_total, over_bulk, store_full;
  logic                            in_fire, high_we, bulk_we, high_re, bulk_re;

  logic                            out_valid_q, out_valid_d, out_load;
  logic [tcbsq_pkg::STAT_W-1:0]    status_q, res_status;
  logic [tcbsq_pkg::TAG_W-1:0]     out_tag_q, res_tag;
  logic [tcbsq_pkg::LEN_W-1:0]     out_len_q, res_len;
  logic [tcbsq_pkg::HANDLE_W-1:0]  out_handle_q, res_handle;
  logic                            out_from_bulk_q, res_from_bulk;
  logic                            out_deliver_q, res_deliver;
  logic [BYTES_W-1:0]              bulk_backlog_q, total_backlog_q;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // tail = (head + count) mod depth
  assign high_tail_sum = HIGH_SW'(high_head_q) + HIGH_SW'(high_count_q);
  assign bulk_tail_sum = BULK_SW'(bulk_head_q) + BULK_SW'(bulk_count_q);
  assign high_tail = (high_tail_sum >= HIGH_SW'(tcbsq_pkg::HIGH_DEPTH))
                   ? tcbsq_pkg::HIGH_AW'(high_tail_sum - HIGH_SW'(tcbsq_pkg::HIGH_DEPTH))
                   : tcbsq_pkg::HIGH_AW'(high_tail_sum);
  assign bulk_tail = (bulk_tail_sum >= BULK_SW'(tcbsq_pkg::BULK_DEPTH))
                   ? tcbsq_pkg::BULK_AW'(bulk_tail_sum - BULK_SW'(tcbsq_pkg::BULK_DEPTH))
                   : tcbsq_pkg::BULK_AW'(bulk_tail_sum);

  assign total_sum  = {1'b0, queued_total_q} + (BYTES_W + 1)'(pkt_len_i);
  assign bulk_sum   = {1'b0, queued_bulk_q} + (BYTES_W + 1)'(pkt_len_i);
  assign over_total = total_sum > {1'b0, total_limit_q};
  assign over_bulk  = low_prio_i && (bulk_sum > {1'b0, bulk_limit_q});
  assign store_full = low_prio_i ? (bulk_count_q >= tcbsq_pkg::BULK_CW'(tcbsq_pkg::BULK_DEPTH))
                                 : (high_count_q >= tcbsq_pkg::HIGH_CW'(tcbsq_pkg::HIGH_DEPTH));

  assign new_desc = '{len: pkt_len_i, tag: pkt_tag_i, handle: buf_handle_i,
                      gen: conn_generation_i};
  assign rd_desc  = sel_bulk_q ? bulk_rd_q : high_rd_q;

  always_comb begin
    state_d        = state_q;
    high_head_d    = high_head_q;
    high_count_d   = high_count_q;
    bulk_head_d    = bulk_head_q;
    bulk_count_d   = bulk_count_q;
    queued_total_d = queued_total_q;
    queued_bulk_d  = queued_bulk_q;
    sel_bulk_d     = sel_bulk_q;
    high_we        = 1'b0;
    bulk_we        = 1'b0;
    high_re        = 1'b0;
    bulk_re        = 1'b0;
    out_load       = 1'b0;
    res_status     = tcbsq_pkg::STAT_OK;
    res_tag        = '0;
    res_len        = '0;
    res_handle     = '0;
    res_from_bulk  = 1'b0;
    res_deliver    = 1'b0;

    if (state_q == ST_READ) begin
      // descriptor is out of the RAM: drain the byte counters, floor at zero
      queued_total_d = (queued_total_q >= BYTES_W'(rd_desc.len))
                     ? queued_total_q - BYTES_W'(rd_desc.len) : '0;
      if (sel_bulk_q) begin
        queued_bulk_d = (queued_bulk_q >= BYTES_W'(rd_desc.len))
                      ? queued_bulk_q - BYTES_W'(rd_desc.len) : '0;
      end
      res_tag       = rd_desc.tag;
      res_len       = rd_desc.len;
      res_handle    = rd_desc.handle;
      res_from_bulk = sel_bulk_q;
      res_deliver   = (rd_desc.gen == gen_q);
      out_load      = 1'b1;
      state_d       = ST_IDLE;
    end else if (in_fire) begin
      case (func_i)
        tcbsq_pkg::FUNC_ENQ: begin
          out_load = 1'b1;
          if (over_total) begin
            res_status = tcbsq_pkg::STAT_TOTAL_REJ;
          end else if (over_bulk) begin
            res_status = tcbsq_pkg::STAT_BULK_REJ;
          end else if (store_full) begin
            res_status = tcbsq_pkg::STAT_FULL;
          end else begin
            queued_total_d = total_sum[BYTES_W-1:0];
            if (low_prio_i) begin
              bulk_we       = 1'b1;
              bulk_count_d  = bulk_count_q + 1'b1;
              queued_bulk_d = bulk_sum[BYTES_W-1:0];
            end else begin
              high_we      = 1'b1;
              high_count_d = high_count_q + 1'b1;
            end
          end
        end
        tcbsq_pkg::FUNC_DEQ: begin
          if (high_count_q != '0) begin
            high_re      = 1'b1;
            sel_bulk_d   = 1'b0;
            high_count_d = high_count_q - 1'b1;
            high_head_d  = (high_head_q == tcbsq_pkg::HIGH_AW'(tcbsq_pkg::HIGH_DEPTH - 1))
                         ? '0 : high_head_q + 1'b1;
            state_d      = ST_READ;
          end else if (bulk_count_q != '0) begin
            bulk_re      = 1'b1;
            sel_bulk_d   = 1'b1;
            bulk_count_d = bulk_count_q - 1'b1;
            bulk_head_d  = (bulk_head_q == tcbsq_pkg::BULK_AW'(tcbsq_pkg::BULK_DEPTH - 1))
                         ? '0 : bulk_head_q + 1'b1;
            state_d      = ST_READ;
          end else begin
            res_status = tcbsq_pkg::STAT_EMPTY;
            out_load   = 1'b1;
          end
        end
        tcbsq_pkg::FUNC_CLR: begin
          high_head_d    = '0;
          high_count_d   = '0;
          bulk_head_d    = '0;
          bulk_count_d   = '0;
          queued_total_d = '0;
          queued_bulk_d  = '0;
          out_load       = 1'b1;
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (high_we) begin
      high_mem[high_tail] <= new_desc;
    end
    if (high_re) begin
      high_rd_q <= high_mem[high_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bulk_we) begin
      bulk_mem[bulk_tail] <= new_desc;
    end
    if (bulk_re) begin
      bulk_rd_q <= bulk_mem[bulk_head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      high_head_q    <= '0;
      high_count_q   <= '0;
      bulk_head_q    <= '0;
      bulk_count_q   <= '0;
      queued_total_q <= '0;
      queued_bulk_q  <= '0;
      out_valid_q    <= 1'b0;
      total_limit_q  <= tcbsq_pkg::TOTAL_LIMIT_RST;
      bulk_limit_q   <= tcbsq_pkg::BULK_LIMIT_RST;
    end else begin
      state_q        <= state_d;
      high_head_q    <= high_head_d;
      high_count_q   <= high_count_d;
      bulk_head_q    <= bulk_head_d;
      bulk_count_q   <= bulk_count_d;
      queued_total_q <= queued_total_d;
      queued_bulk_q  <= queued_bulk_d;
      out_valid_q    <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == tcbsq_pkg::CFG_TOTAL_LIMIT)) begin
        total_limit_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == tcbsq_pkg::CFG_BULK_LIMIT)) begin
        bulk_limit_q <= cfg_data_i;
      end
    end
  end

  // hold the dequeue context for the read cycle; load the result register
  always_ff @(posedge clk_i) begin
    sel_bulk_q <= sel_bulk_d;
    if (in_fire) begin
      gen_q <= conn_generation_i;
    end
    if (out_load) begin
      status_q        <= res_status;
      out_tag_q       <= res_tag;
      out_len_q       <= res_len;
      out_handle_q    <= res_handle;
      out_from_bulk_q <= res_from_bulk;
      out_deliver_q   <= res_deliver;
      bulk_backlog_q  <= queued_bulk_d;
      total_backlog_q <= queued_total_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign out_tag_o       = out_tag_q;
  assign out_len_o       = out_len_q;
  assign out_handle_o    = out_handle_q;
  assign out_from_bulk_o = out_from_bulk_q;
  assign out_deliver_o   = out_deliver_q;
  assign bulk_backlog_o  = bulk_backlog_q;
  assign total_backlog_o = total_backlog_q;

  `ASSERT_ALWAYS(a_bulk_within_total, queued_bulk_q <= queued_total_q, "bulk bytes exceed total")
  `ASSERT_ALWAYS(a_counts_in_range, (high_count_q <= tcbsq_pkg::HIGH_CW'(tcbsq_pkg::HIGH_DEPTH)) && (bulk_count_q <= tcbsq_pkg::BULK_CW'(tcbsq_pkg::BULK_DEPTH)), "store count beyond depth")
  `ASSERT_NEXT(a_deq_reads, in_fire && (func_i == tcbsq_pkg::FUNC_DEQ) && ((high_count_q != '0) || (bulk_count_q != '0)), (state_q == ST_READ) && !out_valid_q, "dequeue did not enter read cycle with free output")
  `ASSERT_NEXT(a_read_loads, state_q == ST_READ, out_valid_q && (state_q == ST_IDLE), "read cycle did not deliver a result")

endmodule

FILE: tb/two_class_byte_bounded_send_queue_unit_test.sv
`timescale 1ns / 100ps

module two_class_byte_bounded_send_queue_unit_test;
  import tcbsq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum int {LEN_NORMAL, LEN_SMALL, LEN_TINY} len_mix_e;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [LEN_W-1:0]    len;
    logic                low;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
    logic [GEN_W-1:0]    gen;
  } queue_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [TAG_W-1:0]    tag;
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
    logic                from_bulk;
    logic                deliver;
    logic [BYTES_W-1:0]  bulk_bytes;
    logic [BYTES_W-1:0]  total_bytes;
  } queue_resp_t;

  class send_queue_scoreboard;
    desc_t high_ring[HIGH_DEPTH];
    desc_t bulk_ring[BULK_DEPTH];
    int unsigned high_rd, high_used, bulk_rd, bulk_used;
    logic [BYTES_W-1:0] bytes_total, bytes_bulk;
    logic [BYTES_W-1:0] total_cap, bulk_cap;
    queue_resp_t awaited[$];
    int unsigned mismatches;

    function new();
      high_rd = 0;
      high_used = 0;
      bulk_rd = 0;
      bulk_used = 0;
      bytes_total = '0;
      bytes_bulk = '0;
      total_cap = TOTAL_LIMIT_RST;
      bulk_cap = BULK_LIMIT_RST;
      mismatches = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] value);
      if (idx == CFG_TOTAL_LIMIT) total_cap = value;
      else if (idx == CFG_BULK_LIMIT) bulk_cap = value;
    endfunction

    // Advance both class queues by one request and return the expected report.
    function queue_resp_t serve_request(queue_req_t req);
      queue_resp_t resp;
      desc_t d;
      logic [BYTES_W:0] sum_total, sum_bulk;
      resp = '0;
      d = '0;
      sum_total = {1'b0, bytes_total} + (BYTES_W + 1)'(req.len);
      sum_bulk = {1'b0, bytes_bulk} + (BYTES_W + 1)'(req.len);
      case (req.func)
        FUNC_ENQ: begin
          if (sum_total > {1'b0, total_cap}) begin
            resp.status = STAT_TOTAL_REJ;
          end else if (req.low && sum_bulk > {1'b0, bulk_cap}) begin
            resp.status = STAT_BULK_REJ;
          end else if (req.low ? (bulk_used >= BULK_DEPTH) : (high_used >= HIGH_DEPTH)) begin
            resp.status = STAT_FULL;
          end else begin
            d.len = req.len;
            d.tag = req.tag;
            d.handle = req.handle;
            d.gen = req.gen;
            if (req.low) begin
              bulk_ring[(bulk_rd + bulk_used) % BULK_DEPTH] = d;
              bulk_used++;
              bytes_bulk = sum_bulk[BYTES_W-1:0];
            end else begin
              high_ring[(high_rd + high_used) % HIGH_DEPTH] = d;
              high_used++;
            end
            bytes_total = sum_total[BYTES_W-1:0];
          end
        end
        FUNC_DEQ: begin
          if (high_used > 0) begin
            d = high_ring[high_rd];
            high_rd = (high_rd + 1) % HIGH_DEPTH;
            high_used--;
          end else if (bulk_used > 0) begin
            d = bulk_ring[bulk_rd];
            bulk_rd = (bulk_rd + 1) % BULK_DEPTH;
            bulk_used--;
            resp.from_bulk = 1'b1;
          end else begin
            resp.status = STAT_EMPTY;
          end
          if (resp.status == STAT_OK) begin
            // floor the byte counters at zero
            bytes_total = (bytes_total >= BYTES_W'(d.len)) ? bytes_total - BYTES_W'(d.len) : '0;
            if (resp.from_bulk)
              bytes_bulk = (bytes_bulk >= BYTES_W'(d.len)) ? bytes_bulk - BYTES_W'(d.len) : '0;
            resp.tag = d.tag;
            resp.len = d.len;
            resp.handle = d.handle;
            resp.deliver = (d.gen == req.gen);
          end
        end
        FUNC_CLR: begin
          high_rd = 0;
          high_used = 0;
          bulk_rd = 0;
          bulk_used = 0;
          bytes_total = '0;
          bytes_bulk = '0;
        end
        default: ;
      endcase
      resp.bulk_bytes = bytes_bulk;
      resp.total_bytes = bytes_total;
      return resp;
    endfunction

    function void note_item(queue_req_t req);
      awaited.push_back(serve_request(req));
    endfunction

    function string describe(queue_resp_t r);
      return $sformatf("status %0d tag %02h len %0d handle %04h bulk %0b deliver %0b bulk_bytes %0d total_bytes %0d",
                       r.status, r.tag, r.len, r.handle, r.from_bulk, r.deliver,
                       r.bulk_bytes, r.total_bytes);
    endfunction

    function void check_result(queue_resp_t got);
      queue_resp_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing pending: %s", describe(got));
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BYTES_W-1:0]  cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i;
  logic [LEN_W-1:0]    pkt_len_i;
  logic                low_prio_i;
  logic [TAG_W-1:0]    pkt_tag_i;
  logic [HANDLE_W-1:0] buf_handle_i;
  logic [GEN_W-1:0]    conn_generation_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STAT_W-1:0]   status_o;
  logic [TAG_W-1:0]    out_tag_o;
  logic [LEN_W-1:0]    out_len_o;
  logic [HANDLE_W-1:0] out_handle_o;
  logic                out_from_bulk_o;
  logic                out_deliver_o;
  logic [BYTES_W-1:0]  bulk_backlog_o;
  logic [BYTES_W-1:0]  total_backlog_o;

  queue_resp_t seen_resp;
  send_queue_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 30;
  int unsigned stall_pct = 30;
  logic [GEN_W-1:0] live_gen = 16'h3c5a;

  two_class_byte_bounded_send_queue_unit i_dut (.*);

  assign seen_resp = {status_o, out_tag_o, out_len_o, out_handle_o, out_from_bulk_o,
                      out_deliver_o, bulk_backlog_o, total_backlog_o};

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_class_byte_bounded_send_queue_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(seen_resp);
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len(len_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      LEN_TINY: return (roll < 80) ? '0 : LEN_W'($urandom_range(1, 15));
      LEN_SMALL: return (roll < 5) ? '0 : LEN_W'($urandom_range(1, 2000));
      default: begin
        if (roll < 5) return '0;
        if (roll < 60) return LEN_W'($urandom_range(1, 4095));
        if (roll < 85) return LEN_W'($urandom_range(4096, 131071));
        if (roll < 97) return LEN_W'($urandom_range(131072, LEN_MAX - 1));
        return LEN_MAX;
      end
    endcase
  endfunction

  // Receiver: hold ready low for random stretches.
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else begin
        out_ready_i = rst_ni;
        if ($urandom_range(0, 99) < stall_pct) hold = pick_gap();
      end
    end
  end

  // Enter and leave just after a falling edge.
  task automatic push_item(queue_req_t req);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = req.func;
    pkt_len_i = req.len;
    low_prio_i = req.low;
    pkt_tag_i = req.tag;
    buf_handle_i = req.handle;
    conn_generation_i = req.gen;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(req);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [FUNC_W-1:0] func, logic [LEN_W-1:0] len, logic low,
                             logic [TAG_W-1:0] tag, logic [HANDLE_W-1:0] handle,
                             logic [GEN_W-1:0] gen);
    queue_req_t req;
    req.func = func;
    req.len = len;
    req.low = low;
    req.tag = tag;
    req.handle = handle;
    req.gen = gen;
    push_item(req);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    sb.set_limit(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Bursts of fills and drains so that both stores reach full and empty.
  task automatic run_random(int unsigned count, int unsigned max_burst, len_mix_e mix);
    queue_req_t req;
    int unsigned burst_kind, burst_left, roll, enq_pct;
    logic fill_low;
    burst_left = 0;
    burst_kind = 0;
    fill_low = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_kind = $urandom_range(0, 2);
        burst_left = $urandom_range(1, max_burst);
        fill_low = 1'($urandom_range(0, 1));
      end
      enq_pct = (burst_kind == 0) ? 88 : (burst_kind == 1) ? 8 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 2) req.func = FUNC_CLR;
      else if (roll < 4) req.func = FUNC_UNUSED;
      else if (roll < 4 + enq_pct) req.func = FUNC_ENQ;
      else req.func = FUNC_DEQ;
      if (burst_kind == 0 && $urandom_range(0, 99) < 85) req.low = fill_low;
      else req.low = 1'($urandom_range(0, 1));
      req.len = pick_len(mix);
      req.tag = TAG_W'($urandom);
      req.handle = HANDLE_W'($urandom);
      if ($urandom_range(0, 99) < 4) live_gen = GEN_W'($urandom);
      req.gen = ($urandom_range(0, 99) < 90) ? live_gen : GEN_W'($urandom);
      push_item(req);
      burst_left--;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TOTAL_LIMIT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    func_i = FUNC_ENQ;
    pkt_len_i = '0;
    low_prio_i = 1'b0;
    pkt_tag_i = '0;
    buf_handle_i = '0;
    conn_generation_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset limits.
    send_fields(FUNC_DEQ, LEN_MAX, 1'b1, 8'hff, 16'hffff, 16'hffff);
    send_fields(FUNC_UNUSED, LEN_MAX, 1'b1, 8'hff, 16'hffff, 16'hffff);
    send_fields(FUNC_ENQ, LEN_MAX, 1'b0, 8'hff, 16'hffff, 16'hffff);
    send_fields(FUNC_ENQ, LEN_MAX, 1'b1, 8'h00, 16'h0000, 16'h0000);
    send_fields(FUNC_ENQ, 21'd2, 1'b1, 8'h11, 16'h1111, 16'h1111);
    send_fields(FUNC_ENQ, LEN_MAX, 1'b0, 8'h5a, 16'h1234, 16'h8001);
    send_fields(FUNC_ENQ, 21'd4, 1'b0, 8'h22, 16'h2222, 16'h2222);
    // over both limits: total check wins
    send_fields(FUNC_ENQ, 21'd4, 1'b1, 8'h33, 16'h3333, 16'h3333);
    // land exactly on the total limit, then a zero-length packet
    send_fields(FUNC_ENQ, 21'd3, 1'b0, 8'h44, 16'h4444, 16'h4444);
    send_fields(FUNC_ENQ, 21'd0, 1'b0, 8'h55, 16'h5555, 16'h5555);
    send_fields(FUNC_DEQ, 21'd0, 1'b0, 8'h00, 16'h0000, 16'hffff);
    send_fields(FUNC_DEQ, LEN_MAX, 1'b1, 8'hff, 16'hffff, 16'h0000);
    send_fields(FUNC_CLR, LEN_MAX, 1'b1, 8'hff, 16'hffff, 16'hffff);
    send_fields(FUNC_DEQ, 21'd0, 1'b0, 8'h00, 16'h0000, 16'h0000);
    send_fields(FUNC_ENQ, 21'd1, 1'b1, 8'h01, 16'h0001, 16'h1234);
    send_fields(FUNC_ENQ, 21'd100000, 1'b0, 8'h80, 16'h8000, 16'h1234);
    send_fields(FUNC_ENQ, 21'd1048576, 1'b1, 8'h7f, 16'h7fff, 16'h4321);
    send_fields(FUNC_DEQ, 21'd0, 1'b0, 8'h00, 16'h0000, 16'h1234);
    send_fields(FUNC_DEQ, 21'd0, 1'b0, 8'h00, 16'h0000, 16'h1234);
    send_fields(FUNC_DEQ, 21'd0, 1'b0, 8'h00, 16'h0000, 16'h1234);
    send_fields(FUNC_DEQ, 21'd0, 1'b0, 8'h00, 16'h0000, 16'h1234);
    send_fields(FUNC_UNUSED, 21'd0, 1'b0, 8'h00, 16'h0000, 16'h0000);
    settle();

    run_random(150, 40, LEN_NORMAL);
    settle();

    // widest limits, back to back with no idling
    write_limit(CFG_TOTAL_LIMIT, '1);
    write_limit(CFG_BULK_LIMIT, '1);
    gap_pct = 0;
    stall_pct = 0;
    run_random(120, 40, LEN_NORMAL);
    settle();

    // zero limits: only empty packets get in, so the high-priority store can fill up
    gap_pct = 30;
    stall_pct = 30;
    write_limit(CFG_TOTAL_LIMIT, '0);
    write_limit(CFG_BULK_LIMIT, '0);
    run_random(60, 80, LEN_TINY);
    settle();

    write_limit(CFG_TOTAL_LIMIT, 24'd30000);
    write_limit(CFG_BULK_LIMIT, 24'd12000);
    run_random(150, 30, LEN_SMALL);
    settle();

    // build a backlog, then drop both limits under it
    write_limit(CFG_TOTAL_LIMIT, '1);
    write_limit(CFG_BULK_LIMIT, '1);
    send_fields(FUNC_CLR, '0, 1'b0, '0, '0, live_gen);
    for (int k = 0; k < 20; k++)
      send_fields(FUNC_ENQ, pick_len(LEN_NORMAL), 1'(k), TAG_W'($urandom),
                  HANDLE_W'($urandom), live_gen);
    settle();
    write_limit(CFG_TOTAL_LIMIT, 24'd1000);
    write_limit(CFG_BULK_LIMIT, 24'd500);
    run_random(80, 20, LEN_SMALL);
    settle();

    write_limit(CFG_TOTAL_LIMIT, TOTAL_LIMIT_RST);
    write_limit(CFG_BULK_LIMIT, BULK_LIMIT_RST);
    gap_pct = 10;
    stall_pct = 60;
    run_random(60, 40, LEN_NORMAL);
    settle();

    repeat (20) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("two_class_byte_bounded_send_queue_unit regression: pass");
    else
      $display("two_class_byte_bounded_send_queue_unit regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tcbsq_pkg.sv
hdl/two_class_byte_bounded_send_queue_unit.sv
tb/two_class_byte_bounded_send_queue_unit_test.sv
